/* design/mcpd_pkg.sv */
`default_nettype none

package mcpd_pkg;

  // Default build values
  localparam int ADC_BITS_DEF   = 12;
  localparam int PWM_PERIOD_DEF = 12000;

  // Field and datapath widths
  localparam int GAIN_W     = 24;
  localparam int VEL_W      = 24;
  localparam int IDES_W     = 22;
  localparam int IMEAS_W    = 22;
  localparam int ERR_W      = 23;
  localparam int VOLT_W     = 23;
  localparam int MAXD_W     = 17;
  localparam int MUL_W      = 24;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int INT_W      = 48;
  localparam int ACC_W      = 58;
  localparam int QUOT_W     = 21;
  localparam int DQ_W       = 19;
  localparam int FRAC_BITS  = 16;
  localparam int HI_SHIFT   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int STEP_W     = 4;

  // Reciprocal of three: floor(x/3) = (x * RECIP3) >> RECIP_SHIFT for x < 2^25
  localparam logic [MUL_W-1:0] RECIP3      = 24'd11184811;
  localparam int               RECIP_SHIFT = 25;
  localparam int               SENSE_GAIN  = 110;

  localparam logic signed [ACC_W-1:0] VOLT_MAX = 58'sd4194303;
  localparam logic signed [ACC_W-1:0] VOLT_MIN = -58'sd4194304;
  localparam logic [MAXD_W-1:0]       FULL_DUTY = 17'd65536;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RES  = 3'd0,
    CFG_BEMF = 3'd1,
    CFG_KP   = 3'd2,
    CFG_KI   = 3'd3,
    CFG_MAXD = 3'd4
  } cfg_idx_t;

  // Microcode field codes
  typedef enum logic [1:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_NO_INPUT,
    JC_OUT_BUSY
  } jc_t;

  typedef enum logic [2:0] {
    MA_RECIP3,
    MA_RES,
    MA_BEMF,
    MA_KP,
    MA_KI,
    MA_PERIOD
  } ma_t;

  typedef enum logic [2:0] {
    MB_NUM,
    MB_IDES,
    MB_VEL,
    MB_ERR,
    MB_INT_HI,
    MB_INT_LO,
    MB_VQ,
    MB_DUTY
  } mb_t;

  typedef enum logic [1:0] {
    AC_NONE,
    AC_LOAD16,
    AC_ADD16,
    AC_ADD8
  } acc_op_t;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_IMEAS,
    LD_ERR,
    LD_INTEG,
    LD_IMAG,
    LD_VOLT,
    LD_DUTY
  } ld_t;

  typedef struct packed {
    logic              accept;
    logic              emit;
    jc_t               jc;
    logic [STEP_W-1:0] jt;
    logic              mul_en;
    ma_t               ma;
    mb_t               mb;
    acc_op_t           acc_op;
    ld_t               ld;
  } cw_t;

  typedef struct packed {
    logic no_input;
    logic out_busy;
  } status_t;

  localparam logic [STEP_W-1:0] ST_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] ST_EMIT = 4'd13;

  // Control store: one control word per step
  function automatic cw_t ucode(logic [STEP_W-1:0] step);
    cw_t cw;
    cw = '0;
    case (step)
      4'd0: begin
        cw.accept = 1'b1;
        cw.jc     = JC_NO_INPUT;
        cw.jt     = ST_WAIT;
      end
      4'd1: begin
        cw.mul_en = 1'b1; cw.ma = MA_RECIP3; cw.mb = MB_NUM;
      end
      4'd2: begin
        cw.ld     = LD_IMEAS;
        cw.mul_en = 1'b1; cw.ma = MA_RES; cw.mb = MB_IDES;
      end
      4'd3: begin
        cw.ld     = LD_ERR;
        cw.acc_op = AC_LOAD16;
        cw.mul_en = 1'b1; cw.ma = MA_BEMF; cw.mb = MB_VEL;
      end
      4'd4: begin
        cw.ld     = LD_INTEG;
        cw.acc_op = AC_ADD16;
        cw.mul_en = 1'b1; cw.ma = MA_KP; cw.mb = MB_ERR;
      end
      4'd5: begin
        cw.ld     = LD_IMAG;
        cw.acc_op = AC_ADD16;
      end
      4'd6: begin
        cw.mul_en = 1'b1; cw.ma = MA_KI; cw.mb = MB_INT_HI;
      end
      4'd7: begin
        cw.acc_op = AC_ADD8;
        cw.mul_en = 1'b1; cw.ma = MA_KI; cw.mb = MB_INT_LO;
      end
      4'd8: begin
        cw.acc_op = AC_ADD16;
      end
      4'd9: begin
        cw.ld = LD_VOLT;
      end
      4'd10: begin
        cw.mul_en = 1'b1; cw.ma = MA_RECIP3; cw.mb = MB_VQ;
      end
      4'd11: begin
        cw.ld = LD_DUTY;
      end
      4'd12: begin
        cw.mul_en = 1'b1; cw.ma = MA_PERIOD; cw.mb = MB_DUTY;
      end
      4'd13: begin
        cw.emit = 1'b1;
        cw.jc   = JC_OUT_BUSY;
        cw.jt   = ST_EMIT;
      end
      default: begin
        cw.jc = JC_ALWAYS;
        cw.jt = ST_WAIT;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

/* design/mcpd_if.sv */
`default_nettype none

interface mcpd_tick_if #(
  parameter int ADC_BITS = mcpd_pkg::ADC_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic                                 motor;
  logic [ADC_BITS-1:0]                  adc_sample;
  logic signed [mcpd_pkg::VEL_W-1:0]    velocity;
  logic signed [mcpd_pkg::IDES_W-1:0]   desired_current;
  logic                                 clear_integral;

  modport source (output valid, motor, adc_sample, velocity, desired_current,
                  clear_integral, input ready);
  modport sink   (input valid, motor, adc_sample, velocity, desired_current,
                  clear_integral, output ready);
endinterface

interface mcpd_drive_if #(
  parameter int PWM_PERIOD = mcpd_pkg::PWM_PERIOD_DEF
);
  localparam int TICK_W = $clog2(PWM_PERIOD + 1);

  logic                                 valid;
  logic                                 ready;
  logic                                 motor_id;
  logic                                 dir_forward;
  logic                                 dir_reverse;
  logic [TICK_W-1:0]                    pulse_ticks;
  logic signed [mcpd_pkg::VOLT_W-1:0]   drive_voltage;
  logic signed [mcpd_pkg::IMEAS_W-1:0]  measured_current;

  modport source (output valid, motor_id, dir_forward, dir_reverse, pulse_ticks,
                  drive_voltage, measured_current, input ready);
  modport sink   (input valid, motor_id, dir_forward, dir_reverse, pulse_ticks,
                  drive_voltage, measured_current, output ready);
endinterface

interface mcpd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [mcpd_pkg::CFG_IDX_W-1:0]       index;
  logic [mcpd_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/motor_current_pi_drive.sv */
// Channel  Dir  Handshake     Payload
// tick     in   valid/ready   motor, adc_sample, velocity, desired_current, clear_integral
// drive    out  valid/ready   motor_id, dir_forward, dir_reverse, pulse_ticks,
//                             drive_voltage, measured_current
// cfg      in   valid/ready   index, data (ready always high)
//
// One item runs as an accept step followed by 13 program steps that run every
// product through one shared 24x24 multiplier.
// The integrator is split into two multiplier passes, which sets the step count.
// Reset is synchronous: step counter to the accept step, gains and both
// integrators to zero, output empty.
// A stalled output holds the program at its emit step; the next item waits in tick.
`default_nettype none

module motor_current_pi_drive #(
  parameter int ADC_BITS   = mcpd_pkg::ADC_BITS_DEF,
  parameter int PWM_PERIOD = mcpd_pkg::PWM_PERIOD_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  mcpd_tick_if.sink    tick,
  mcpd_drive_if.source drive,
  mcpd_cfg_if.sink     cfg
);

  mcpd_pkg::cw_t     cw;
  mcpd_pkg::status_t st;

  // Step counter and control store
  mcpd_seq u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cw  (cw)
  );

  // Datapath driven by the control word
  mcpd_dp #(
    .ADC_BITS   (ADC_BITS),
    .PWM_PERIOD (PWM_PERIOD)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cw    (cw),
    .st    (st),
    .tick  (tick),
    .drive (drive),
    .cfg   (cfg)
  );

endmodule

`default_nettype wire

/* design/mcpd_seq.sv */
`default_nettype none

module mcpd_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mcpd_pkg::status_t st,
  output mcpd_pkg::cw_t          cw
);

  logic [mcpd_pkg::STEP_W-1:0] step;
  logic [mcpd_pkg::STEP_W-1:0] step_next;
  logic                        take;

  // Fetch the control word for this step
  assign cw = mcpd_pkg::ucode(step);

  // Resolve the jump condition
  always_comb begin
    case (cw.jc)
      mcpd_pkg::JC_NONE:     take = 1'b0;
      mcpd_pkg::JC_ALWAYS:   take = 1'b1;
      mcpd_pkg::JC_NO_INPUT: take = st.no_input;
      mcpd_pkg::JC_OUT_BUSY: take = st.out_busy;
      default:               take = 1'b0;
    endcase
  end

  // Jump, wrap after the emit step, or advance
  always_comb begin
    if (take) begin
      step_next = cw.jt;
    end else if (cw.emit) begin
      step_next = mcpd_pkg::ST_WAIT;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= mcpd_pkg::ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

/* design/mcpd_dp.sv */
`default_nettype none

module mcpd_dp #(
  parameter int ADC_BITS   = mcpd_pkg::ADC_BITS_DEF,
  parameter int PWM_PERIOD = mcpd_pkg::PWM_PERIOD_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mcpd_pkg::cw_t cw,
  output mcpd_pkg::status_t  st,
  mcpd_tick_if.sink          tick,
  mcpd_drive_if.source       drive,
  mcpd_cfg_if.sink           cfg
);

  localparam int TICK_W = $clog2(PWM_PERIOD + 1);
  localparam int MUL_W  = mcpd_pkg::MUL_W;
  localparam int PROD_W = mcpd_pkg::PROD_W;
  localparam int INT_W  = mcpd_pkg::INT_W;
  localparam int ACC_W  = mcpd_pkg::ACC_W;
  localparam int ERR_W  = mcpd_pkg::ERR_W;
  localparam int VOLT_W = mcpd_pkg::VOLT_W;
  localparam int IM_W   = mcpd_pkg::IMEAS_W;
  localparam int ID_W   = mcpd_pkg::IDES_W;
  localparam int VEL_W  = mcpd_pkg::VEL_W;
  localparam int MAXD_W = mcpd_pkg::MAXD_W;
  localparam int DQ_W   = mcpd_pkg::DQ_W;
  localparam logic [ADC_BITS-1:0] ADC_MID = ADC_BITS'(1) << (ADC_BITS - 1);

  // Configuration registers
  logic [mcpd_pkg::GAIN_W-1:0] res_gain, bemf_gain, kp_gain, ki_gain;
  logic [MAXD_W-1:0]           max_duty;

  // Latched input item
  logic                        ch;
  logic [ADC_BITS-1:0]         adc;
  logic signed [VEL_W-1:0]     vel;
  logic signed [ID_W-1:0]      ides;
  logic                        clr;

  // Working registers
  logic [PROD_W-1:0]           prod;
  logic                        prod_neg;
  logic signed [IM_W-1:0]      imeas;
  logic signed [ERR_W-1:0]     err;
  logic signed [INT_W-1:0]     integ [2];
  logic signed [INT_W-1:0]     integ_cur;
  logic [INT_W-1:0]            imag;
  logic signed [ACC_W-1:0]     acc;
  logic signed [VOLT_W-1:0]    volt;
  logic [MAXD_W-1:0]           duty;

  // Combinational datapath
  logic [ADC_BITS-1:0]         dmag;
  logic                        dneg;
  logic [MUL_W-1:0]            num1;
  logic [mcpd_pkg::QUOT_W-1:0] quot;
  logic [ID_W-1:0]             ides_mag;
  logic [VEL_W-1:0]            vel_mag;
  logic [ERR_W-1:0]            err_mag;
  logic [VOLT_W-1:0]           vmag;
  logic [MUL_W-1:0]            mul_a, mul_b;
  logic                        mul_neg;
  logic signed [INT_W-1:0]     ibase;
  logic signed [INT_W:0]       isum;
  logic signed [INT_W-1:0]     isat;
  logic [ACC_W-1:0]            tmag;
  logic signed [ACC_W-1:0]     term;
  logic signed [VOLT_W-1:0]    vsat;
  logic [DQ_W-1:0]             dq;
  logic [MAXD_W-1:0]           lim;
  logic [MAXD_W-1:0]           duty_next;
  logic                        in_xfer, out_load;

  assign tick.ready = cw.accept;
  assign cfg.ready  = 1'b1;
  assign in_xfer    = tick.valid && cw.accept;

  assign st.no_input = !tick.valid;
  assign st.out_busy = drive.valid && !drive.ready;
  assign out_load    = cw.emit && !st.out_busy;

  // Sensor offset removal and scaling to the divide-by-three numerator
  always_comb begin
    dneg = !adc[ADC_BITS-1];
    dmag = adc[ADC_BITS-1] ? (adc - ADC_MID) : (ADC_MID - adc);
    num1 = ((MUL_W'(dmag) * MUL_W'(mcpd_pkg::SENSE_GAIN)) << (16 - ADC_BITS))
           + MUL_W'(1);
    quot = prod[mcpd_pkg::RECIP_SHIFT +: mcpd_pkg::QUOT_W];
  end

  // Operand magnitudes
  always_comb begin
    ides_mag = ides[ID_W-1] ? ID_W'(-ides) : ID_W'(ides);
    vel_mag  = vel[VEL_W-1] ? VEL_W'(-vel) : VEL_W'(vel);
    err_mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    vmag     = volt[VOLT_W-1] ? VOLT_W'(-volt) : VOLT_W'(volt);
  end

  // Multiplier operand select
  always_comb begin
    case (cw.ma)
      mcpd_pkg::MA_RECIP3: mul_a = mcpd_pkg::RECIP3;
      mcpd_pkg::MA_RES:    mul_a = res_gain;
      mcpd_pkg::MA_BEMF:   mul_a = bemf_gain;
      mcpd_pkg::MA_KP:     mul_a = kp_gain;
      mcpd_pkg::MA_KI:     mul_a = ki_gain;
      mcpd_pkg::MA_PERIOD: mul_a = MUL_W'(PWM_PERIOD);
      default:             mul_a = '0;
    endcase
    mul_neg = 1'b0;
    case (cw.mb)
      mcpd_pkg::MB_NUM:    mul_b = num1;
      mcpd_pkg::MB_IDES: begin
        mul_b   = MUL_W'(ides_mag);
        mul_neg = ides[ID_W-1];
      end
      mcpd_pkg::MB_VEL: begin
        mul_b   = vel_mag;
        mul_neg = vel[VEL_W-1];
      end
      mcpd_pkg::MB_ERR: begin
        mul_b   = MUL_W'(err_mag);
        mul_neg = err[ERR_W-1];
      end
      mcpd_pkg::MB_INT_HI: begin
        mul_b   = imag[INT_W-1:MUL_W];
        mul_neg = integ_cur[INT_W-1];
      end
      mcpd_pkg::MB_INT_LO: begin
        mul_b   = imag[MUL_W-1:0];
        mul_neg = integ_cur[INT_W-1];
      end
      mcpd_pkg::MB_VQ:     mul_b = MUL_W'(vmag[VOLT_W-1:2]);
      mcpd_pkg::MB_DUTY:   mul_b = MUL_W'(duty);
      default:             mul_b = '0;
    endcase
  end

  // Integrator update with saturation
  always_comb begin
    ibase = clr ? '0 : integ[ch];
    isum  = (INT_W + 1)'(ibase) + (INT_W + 1)'(err);
    if (isum[INT_W] != isum[INT_W-1]) begin
      isat = isum[INT_W] ? {1'b1, {(INT_W - 1){1'b0}}} : {1'b0, {(INT_W - 1){1'b1}}};
    end else begin
      isat = isum[INT_W-1:0];
    end
  end

  // Scaled product term for the voltage sum
  always_comb begin
    if (cw.acc_op == mcpd_pkg::AC_ADD8) begin
      tmag = ACC_W'(prod) << mcpd_pkg::HI_SHIFT;
    end else begin
      tmag = ACC_W'(prod >> mcpd_pkg::FRAC_BITS);
    end
    term = prod_neg ? -$signed(tmag) : $signed(tmag);
  end

  // Voltage clamp, duty quotient and limit
  always_comb begin
    if (acc > mcpd_pkg::VOLT_MAX) begin
      vsat = VOLT_W'(mcpd_pkg::VOLT_MAX);
    end else if (acc < mcpd_pkg::VOLT_MIN) begin
      vsat = VOLT_W'(mcpd_pkg::VOLT_MIN);
    end else begin
      vsat = acc[VOLT_W-1:0];
    end
    dq  = prod[mcpd_pkg::RECIP_SHIFT +: DQ_W];
    lim = (max_duty > mcpd_pkg::FULL_DUTY) ? mcpd_pkg::FULL_DUTY : max_duty;
    duty_next = (DQ_W'(lim) < dq) ? lim : dq[MAXD_W-1:0];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      res_gain  <= '0;
      bemf_gain <= '0;
      kp_gain   <= '0;
      ki_gain   <= '0;
      max_duty  <= '0;
    end else if (cfg.valid) begin
      case (mcpd_pkg::cfg_idx_t'(cfg.index))
        mcpd_pkg::CFG_RES:  res_gain  <= cfg.data;
        mcpd_pkg::CFG_BEMF: bemf_gain <= cfg.data;
        mcpd_pkg::CFG_KP:   kp_gain   <= cfg.data;
        mcpd_pkg::CFG_KI:   ki_gain   <= cfg.data;
        mcpd_pkg::CFG_MAXD: max_duty  <= cfg.data[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input item on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch   <= tick.motor;
      adc  <= tick.adc_sample;
      vel  <= tick.velocity;
      ides <= tick.desired_current;
      clr  <= tick.clear_integral;
    end
  end

  // Shared multiplier and working registers
  always_ff @(posedge clk) begin
    if (cw.mul_en) begin
      prod     <= PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_neg <= mul_neg;
    end
    case (cw.acc_op)
      mcpd_pkg::AC_LOAD16: acc <= term;
      mcpd_pkg::AC_ADD16,
      mcpd_pkg::AC_ADD8:   acc <= acc + term;
      default: ;
    endcase
    case (cw.ld)
      mcpd_pkg::LD_IMEAS: imeas <= dneg ? -$signed(IM_W'(quot)) : $signed(IM_W'(quot));
      mcpd_pkg::LD_ERR:   err   <= ERR_W'(ides) - ERR_W'(imeas);
      mcpd_pkg::LD_INTEG: integ_cur <= isat;
      mcpd_pkg::LD_IMAG:  imag  <= integ_cur[INT_W-1] ? INT_W'(-integ_cur)
                                                       : INT_W'(integ_cur);
      mcpd_pkg::LD_VOLT:  volt  <= vsat;
      mcpd_pkg::LD_DUTY:  duty  <= duty_next;
      default: ;
    endcase
  end

  // Per-motor integrators
  always_ff @(posedge clk) begin
    if (rst) begin
      integ[0] <= '0;
      integ[1] <= '0;
    end else if (cw.ld == mcpd_pkg::LD_INTEG) begin
      integ[ch] <= isat;
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      drive.valid <= 1'b0;
    end else if (out_load) begin
      drive.valid <= 1'b1;
    end else if (drive.ready) begin
      drive.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive.motor_id         <= ch;
      drive.dir_forward      <= !volt[VOLT_W-1] && (volt != '0);
      drive.dir_reverse      <= volt[VOLT_W-1];
      drive.pulse_ticks      <= TICK_W'(prod >> mcpd_pkg::FRAC_BITS);
      drive.drive_voltage    <= volt;
      drive.measured_current <= imeas;
    end
  end

endmodule

`default_nettype wire

/* design/mcpd_checker.sv */
`default_nettype none

module mcpd_checker #(
  parameter int PWM_PERIOD = mcpd_pkg::PWM_PERIOD_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              dir_forward,
  input wire logic                              dir_reverse,
  input wire logic [$clog2(PWM_PERIOD+1)-1:0]   pulse_ticks,
  input wire logic signed [mcpd_pkg::VOLT_W-1:0] drive_voltage
);

  localparam int TICK_W = $clog2(PWM_PERIOD + 1);

  // Hold the result while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pulse_ticks)
      && $stable(drive_voltage))
    else $error("drive result changed while stalled");

  // Direction pins follow the voltage sign, coast at zero
  a_dir_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dir_forward == (!drive_voltage[mcpd_pkg::VOLT_W-1]
      && drive_voltage != '0)) && (dir_reverse == drive_voltage[mcpd_pkg::VOLT_W-1]))
    else $error("direction pins disagree with voltage");

  // Pulse within the period, and zero when coasting
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pulse_ticks <= TICK_W'(PWM_PERIOD))
      && ((dir_forward || dir_reverse) || pulse_ticks == '0))
    else $error("pulse width out of range");

  // A result never appears right after an input transfer
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early after input transfer");

endmodule

bind motor_current_pi_drive mcpd_checker #(
  .PWM_PERIOD (PWM_PERIOD)
) u_mcpd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (tick.valid),
  .in_ready      (tick.ready),
  .out_valid     (drive.valid),
  .out_ready     (drive.ready),
  .dir_forward   (drive.dir_forward),
  .dir_reverse   (drive.dir_reverse),
  .pulse_ticks   (drive.pulse_ticks),
  .drive_voltage (drive.drive_voltage)
);

`default_nettype wire
